@@ design/csh_pkg.sv @@
// Package with the shared constants and types of the capsule-sphere hit test.
package csh_pkg;

    // Multiplier slice width and the fixed latency of the pipelined multiplier.
    localparam int LIMB_W  = 32;
    localparam int MUL_LAT = 5;

    // Item latency from the accepting edge to the result strobe.
    localparam int LAT = 3 * MUL_LAT + 5;

    // Cycles the config-derived products need to settle after a write or reset.
    localparam int SETTLE = 2 * MUL_LAT + 2;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_CENTER_X = 3'd0;
    localparam t_reg_idx REG_CENTER_Y = 3'd1;
    localparam t_reg_idx REG_CENTER_Z = 3'd2;
    localparam t_reg_idx REG_AXIS_X   = 3'd3;
    localparam t_reg_idx REG_AXIS_Y   = 3'd4;
    localparam t_reg_idx REG_AXIS_Z   = 3'd5;
    localparam t_reg_idx REG_LENGTH   = 3'd6;
    localparam t_reg_idx REG_RADIUS   = 3'd7;

    // Comparison flags carried alongside an item while its last products form.
    typedef struct packed {
        logic on_seg;
        logic cross_hit;
    } t_late_flags;

    typedef struct packed {
        logic near_hit;
        logic a4_neg;
    } t_early_flags;

endpackage

@@ design/capsule_sphere_hit_test_top.sv @@
// Top level of the capsule versus sphere hit test pipeline.
//
// The capsule (center, axis direction, full length, radius) sits in eight
// registers written through i_cfg_we, i_cfg_idx and i_cfg_data; a write
// takes effect at the clock edge and has no read-back. Each sphere is one
// item: it is accepted at a rising edge where start is high and busy is low.
// The answer then appears on o_hit for one cycle, marked
// by o_valid. A new item may be accepted in every cycle while busy is
// low, so the block sustains one item per cycle. Each item goes through
// three chained multiplier passes and five register stages.
// The test is exact integer arithmetic on the raw fixed-point values, so
// there is no rounding anywhere.
// busy is high after reset and after each configuration write,
// while the squared axis length and related products are rebuilt from the
// new registers. Otherwise busy stays low.
// Reset (synchronous, active low) restores the default capsule and drops
// every item in flight. The receiver cannot stall the output; results are
// simply presented and taken.
module capsule_sphere_hit_test_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [31:0]    i_sphere_x,
    input  logic signed [31:0]    i_sphere_y,
    input  logic signed [31:0]    i_sphere_z,
    input  logic [30:0]           i_sphere_radius,
    input  logic                  i_cfg_we,
    input  csh_pkg::t_reg_idx     i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_valid,
    output logic                  o_hit
);
    import csh_pkg::*;

    // Configuration registers.
    logic signed [31:0] r_cx, r_cy, r_cz, r_dx, r_dy, r_dz;
    logic [30:0]        r_len, r_rc;
    logic [3:0]         r_settle;
    logic [LAT-1:0]     r_vld;
    logic               w_accept;

    assign w_accept = start && !busy;
    assign busy     = (r_settle != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_dx     <= 32'sd65536;
            r_dy     <= '0;
            r_dz     <= '0;
            r_len    <= 31'd65536;
            r_rc     <= '0;
            r_settle <= 4'(SETTLE);
            r_vld    <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
            if (i_cfg_we) begin
                r_settle <= 4'(SETTLE);
                case (i_cfg_idx)
                    REG_CENTER_X: r_cx  <= i_cfg_data;
                    REG_CENTER_Y: r_cy  <= i_cfg_data;
                    REG_CENTER_Z: r_cz  <= i_cfg_data;
                    REG_AXIS_X:   r_dx  <= i_cfg_data;
                    REG_AXIS_Y:   r_dy  <= i_cfg_data;
                    REG_AXIS_Z:   r_dz  <= i_cfg_data;
                    REG_LENGTH:   r_len <= i_cfg_data[30:0];
                    REG_RADIUS:   r_rc  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end else if (busy) begin
                r_settle <= r_settle - 4'd1;
            end
        end
    end

    // Products that depend only on the capsule: |d|^2, L^2 and L^2 |d|^2.
    // They are rebuilt continuously and are stable whenever busy is low.
    logic signed [63:0]  w_dxx, w_dyy, w_dzz, w_l2;
    logic signed [67:0]  r_dd;
    logic signed [31:0]  w_len_s;
    logic signed [131:0] w_l2dd;
    logic                w_special;

    assign w_len_s = {1'b0, r_len};

    csh_mul #(.WA(32), .WB(32)) u_dxx (.i_clk(i_clk), .i_a(r_dx), .i_b(r_dx), .o_p(w_dxx));
    csh_mul #(.WA(32), .WB(32)) u_dyy (.i_clk(i_clk), .i_a(r_dy), .i_b(r_dy), .o_p(w_dyy));
    csh_mul #(.WA(32), .WB(32)) u_dzz (.i_clk(i_clk), .i_a(r_dz), .i_b(r_dz), .o_p(w_dzz));
    csh_mul #(.WA(32), .WB(32)) u_l2 (.i_clk(i_clk), .i_a(w_len_s), .i_b(w_len_s), .o_p(w_l2));

    always_ff @(posedge i_clk) begin
        r_dd <= 68'(w_dxx) + 68'(w_dyy) + 68'(w_dzz);
    end

    csh_mul #(.WA(64), .WB(68)) u_l2dd (.i_clk(i_clk), .i_a(w_l2), .i_b(r_dd), .o_p(w_l2dd));

    // A zero axis or zero length pins the nearest point to the center.
    assign w_special = (r_dx == '0 && r_dy == '0 && r_dz == '0) || (r_len == '0);

    // Stage 0: offset from the capsule center and the radius sum.
    logic signed [32:0] r0_vx, r0_vy, r0_vz, r0_rs;
    logic signed [32:0] w_dx33, w_dy33, w_dz33;

    assign w_dx33 = 33'(r_dx);
    assign w_dy33 = 33'(r_dy);
    assign w_dz33 = 33'(r_dz);

    always_ff @(posedge i_clk) begin
        r0_vx <= 33'(i_sphere_x) - 33'(r_cx);
        r0_vy <= 33'(i_sphere_y) - 33'(r_cy);
        r0_vz <= 33'(i_sphere_z) - 33'(r_cz);
        r0_rs <= {2'b00, r_rc} + {2'b00, i_sphere_radius};
    end

    // First multiplier pass: squares, dot terms and cross-product terms.
    logic signed [65:0] w_vxx, w_vyy, w_vzz, w_vxdx, w_vydy, w_vzdz;
    logic signed [65:0] w_vydz, w_vzdy, w_vzdx, w_vxdz, w_vxdy, w_vydx, w_rr;

    csh_mul #(.WA(33), .WB(33)) u_vxx (.i_clk(i_clk), .i_a(r0_vx), .i_b(r0_vx), .o_p(w_vxx));
    csh_mul #(.WA(33), .WB(33)) u_vyy (.i_clk(i_clk), .i_a(r0_vy), .i_b(r0_vy), .o_p(w_vyy));
    csh_mul #(.WA(33), .WB(33)) u_vzz (.i_clk(i_clk), .i_a(r0_vz), .i_b(r0_vz), .o_p(w_vzz));
    csh_mul #(.WA(33), .WB(33)) u_vxdx (.i_clk(i_clk), .i_a(r0_vx), .i_b(w_dx33), .o_p(w_vxdx));
    csh_mul #(.WA(33), .WB(33)) u_vydy (.i_clk(i_clk), .i_a(r0_vy), .i_b(w_dy33), .o_p(w_vydy));
    csh_mul #(.WA(33), .WB(33)) u_vzdz (.i_clk(i_clk), .i_a(r0_vz), .i_b(w_dz33), .o_p(w_vzdz));
    csh_mul #(.WA(33), .WB(33)) u_vydz (.i_clk(i_clk), .i_a(r0_vy), .i_b(w_dz33), .o_p(w_vydz));
    csh_mul #(.WA(33), .WB(33)) u_vzdy (.i_clk(i_clk), .i_a(r0_vz), .i_b(w_dy33), .o_p(w_vzdy));
    csh_mul #(.WA(33), .WB(33)) u_vzdx (.i_clk(i_clk), .i_a(r0_vz), .i_b(w_dx33), .o_p(w_vzdx));
    csh_mul #(.WA(33), .WB(33)) u_vxdz (.i_clk(i_clk), .i_a(r0_vx), .i_b(w_dz33), .o_p(w_vxdz));
    csh_mul #(.WA(33), .WB(33)) u_vxdy (.i_clk(i_clk), .i_a(r0_vx), .i_b(w_dy33), .o_p(w_vxdy));
    csh_mul #(.WA(33), .WB(33)) u_vydx (.i_clk(i_clk), .i_a(r0_vy), .i_b(w_dx33), .o_p(w_vydx));
    csh_mul #(.WA(33), .WB(33)) u_rr (.i_clk(i_clk), .i_a(r0_rs), .i_b(r0_rs), .o_p(w_rr));

    // Stage 1: |v|^2, v.d, the components of v x d, and R^2.
    logic signed [67:0] r1_vv, r1_dot, r1_kx, r1_ky, r1_kz, r1_r2;

    always_ff @(posedge i_clk) begin
        r1_vv  <= 68'(w_vxx) + 68'(w_vyy) + 68'(w_vzz);
        r1_dot <= 68'(w_vxdx) + 68'(w_vydy) + 68'(w_vzdz);
        r1_kx  <= 68'(w_vydz) - 68'(w_vzdy);
        r1_ky  <= 68'(w_vzdx) - 68'(w_vxdz);
        r1_kz  <= 68'(w_vxdy) - 68'(w_vydx);
        r1_r2  <= 68'(w_rr);
    end

    // Stage 2: A4 = 4|v|^2 + L^2 - 4R^2 and the degenerate-case compare.
    logic signed [71:0] r2_a4;
    logic signed [67:0] r2_dot, r2_kx, r2_ky, r2_kz, r2_r2;
    logic               r2_near;
    t_early_flags       w_fl_early;

    always_ff @(posedge i_clk) begin
        r2_a4   <= (72'(r1_vv) <<< 2) + 72'(w_l2) - (72'(r1_r2) <<< 2);
        r2_near <= r1_vv < r1_r2;
        r2_dot  <= r1_dot;
        r2_kx   <= r1_kx;
        r2_ky   <= r1_ky;
        r2_kz   <= r1_kz;
        r2_r2   <= r1_r2;
    end

    assign w_fl_early.near_hit = r2_near;
    assign w_fl_early.a4_neg   = r2_a4[71];

    // Second multiplier pass.
    logic signed [135:0] w_dot2, w_kx2, w_ky2, w_kz2, w_r2dd;
    logic signed [143:0] w_a4sq;

    csh_mul #(.WA(68), .WB(68)) u_dot2 (.i_clk(i_clk), .i_a(r2_dot), .i_b(r2_dot), .o_p(w_dot2));
    csh_mul #(.WA(68), .WB(68)) u_kx2 (.i_clk(i_clk), .i_a(r2_kx), .i_b(r2_kx), .o_p(w_kx2));
    csh_mul #(.WA(68), .WB(68)) u_ky2 (.i_clk(i_clk), .i_a(r2_ky), .i_b(r2_ky), .o_p(w_ky2));
    csh_mul #(.WA(68), .WB(68)) u_kz2 (.i_clk(i_clk), .i_a(r2_kz), .i_b(r2_kz), .o_p(w_kz2));
    csh_mul #(.WA(68), .WB(68)) u_r2dd (.i_clk(i_clk), .i_a(r2_r2), .i_b(r_dd), .o_p(w_r2dd));
    csh_mul #(.WA(72), .WB(72)) u_a4sq (.i_clk(i_clk), .i_a(r2_a4), .i_b(r2_a4), .o_p(w_a4sq));

    // Stage 3: |v x d|^2 and the registered second-pass products.
    logic signed [137:0] r3_c2;
    logic signed [135:0] r3_dot2, r3_r2dd;
    logic signed [143:0] r3_a4sq;
    t_late_flags         w_fl_late_in, w_fl_late;
    t_early_flags        w_fl_early_d;

    always_ff @(posedge i_clk) begin
        r3_c2   <= 138'(w_kx2) + 138'(w_ky2) + 138'(w_kz2);
        r3_dot2 <= w_dot2;
        r3_r2dd <= w_r2dd;
        r3_a4sq <= w_a4sq;
    end

    // The projection lies within the segment when L^2 |d|^2 >= 4 (v.d)^2.
    assign w_fl_late_in.on_seg    = !(140'(w_l2dd) < (140'(r3_dot2) <<< 2));
    assign w_fl_late_in.cross_hit = r3_c2 < 138'(r3_r2dd);

    csh_dly #(.W($bits(t_late_flags)), .N(MUL_LAT)) u_dly_late (
        .i_clk (i_clk),
        .i_d   (w_fl_late_in),
        .o_q   (w_fl_late)
    );

    csh_dly #(.W($bits(t_early_flags)), .N(2 * MUL_LAT + 1)) u_dly_early (
        .i_clk (i_clk),
        .i_d   (w_fl_early),
        .o_q   (w_fl_early_d)
    );

    // Third multiplier pass for the end-cap test.
    logic signed [211:0] w_lhs;
    logic signed [199:0] w_l2dot2;
    logic                w_far_hit;
    logic                w_hit;
    logic                r_hit;

    csh_mul #(.WA(144), .WB(68)) u_lhs (.i_clk(i_clk), .i_a(r3_a4sq), .i_b(r_dd), .o_p(w_lhs));
    csh_mul #(.WA(64), .WB(136)) u_rhs (
        .i_clk (i_clk),
        .i_a   (w_l2),
        .i_b   (r3_dot2),
        .o_p   (w_l2dot2)
    );

    // Beyond an end: hit when A4 < 0 or A4^2 |d|^2 < 16 L^2 (v.d)^2.
    assign w_far_hit = w_fl_early_d.a4_neg || (213'(w_lhs) < (213'(w_l2dot2) <<< 4));

    always_comb begin
        if (w_special) begin
            w_hit = w_fl_early_d.near_hit;
        end else if (w_fl_late.on_seg) begin
            w_hit = w_fl_late.cross_hit;
        end else begin
            w_hit = w_far_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= w_hit;
    end

    assign o_valid = r_vld[LAT-1];
    assign o_hit   = r_hit;

    // Every strobe traces back to an item accepted a fixed latency earlier.
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LAT))
        else $error("result strobe without a matching accepted item");

    // A configuration write must hold off new items while products settle.
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("block not busy after a configuration write");

    // No item is accepted while the derived capsule products are settling.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !r_vld[0])
        else $error("item entered the pipeline while busy");

endmodule

@@ design/csh_mul.sv @@
// Pipelined signed multiplier built from 32x32 partial products.
module csh_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                    i_clk,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    import csh_pkg::*;

    localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
    localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
    localparam int WR = NB * LIMB_W + LIMB_W;
    localparam int WM = (NA + NB) * LIMB_W;

    logic [WA-1:0]          n_ma;
    logic [WB-1:0]          n_mb;
    logic [NA*LIMB_W-1:0]   r_ma;
    logic [NB*LIMB_W-1:0]   r_mb;
    logic [MUL_LAT-2:0]     r_neg;
    logic [2*LIMB_W-1:0]    r_pp [NA][NB];
    logic [WR-1:0]          n_row [NA];
    logic [WR-1:0]          r_row [NA];
    logic [WM-1:0]          n_mag;
    logic [WM-1:0]          r_mag;
    logic signed [WA+WB-1:0] r_p;

    // Magnitudes first, so the slices multiply as unsigned values.
    assign n_ma = i_a[WA-1] ? (~i_a + 1'b1) : i_a;
    assign n_mb = i_b[WB-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (WR'(r_pp[i][j]) << (LIMB_W * j));
            end
        end
    end

    always_comb begin
        n_mag = '0;
        for (int i = 0; i < NA; i++) begin
            n_mag = n_mag + (WM'(r_row[i]) << (LIMB_W * i));
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma  <= (NA*LIMB_W)'(n_ma);
        r_mb  <= (NB*LIMB_W)'(n_mb);
        r_neg <= {r_neg[MUL_LAT-3:0], i_a[WA-1] ^ i_b[WB-1]};
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i][j] <= r_ma[LIMB_W*i +: LIMB_W] * r_mb[LIMB_W*j +: LIMB_W];
            end
        end
        r_row <= n_row;
        r_mag <= n_mag;
        r_p   <= r_neg[MUL_LAT-2] ? (WA+WB)'(~r_mag + 1'b1) : (WA+WB)'(r_mag);
    end

    assign o_p = r_p;

endmodule

@@ design/csh_dly.sv @@
// Fixed-length delay line for flags that travel beside the multipliers.
module csh_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sh [N];

    always_ff @(posedge i_clk) begin
        r_sh[0] <= i_d;
        for (int k = 1; k < N; k++) begin
            r_sh[k] <= r_sh[k-1];
        end
    end

    assign o_q = r_sh[N-1];

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the capsule versus sphere hit test block.
`timescale 1ns / 1ps

module tb_top;
    import csh_pkg::*;

    typedef logic signed [255:0] t_wide;

    // Every item gives exactly one result, so spheres are tracked in order.
    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic signed [31:0] i_sphere_x;
    logic signed [31:0] i_sphere_y;
    logic signed [31:0] i_sphere_z;
    logic [30:0] i_sphere_radius;
    logic       i_cfg_we;
    t_reg_idx   i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic       o_valid;
    logic       o_hit;

    // Local copy of the capsule held in the block's registers.
    logic signed [31:0] cap_cx, cap_cy, cap_cz;
    logic signed [31:0] cap_dx, cap_dy, cap_dz;
    logic [30:0] cap_len;
    logic [30:0] cap_rad;

    bit  expected_hits[$];
    int  error_count;
    int  stall_cycles;
    bit  no_idle;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic signed [31:0] ONE = 32'sd65536;

    capsule_sphere_hit_test_top uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_sphere_x(i_sphere_x),
        .i_sphere_y(i_sphere_y),
        .i_sphere_z(i_sphere_z),
        .i_sphere_radius(i_sphere_radius),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_hit(o_hit)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Exact overlap test on the raw integers. Square roots and divisions are
    // removed by squaring both sides, so 256-bit products never overflow.
    function automatic bit sphere_overlaps(logic signed [31:0] sx, logic signed [31:0] sy,
                                           logic signed [31:0] sz, logic [30:0] sr);
        t_wide vx, vy, vz, dx, dy, dz;
        t_wide vv, rsum, r2, l2, dd, dt, cx, cy, cz, a4;
        vx = sx - cap_cx;
        vy = sy - cap_cy;
        vz = sz - cap_cz;
        dx = cap_dx;
        dy = cap_dy;
        dz = cap_dz;
        vv = vx * vx + vy * vy + vz * vz;
        rsum = t_wide'(cap_rad) + t_wide'(sr);
        r2 = rsum * rsum;
        // A degenerate axis collapses the capsule to a sphere at its center.
        if ((dx == 0 && dy == 0 && dz == 0) || cap_len == 0) begin
            return vv < r2;
        end
        l2 = t_wide'(cap_len) * t_wide'(cap_len);
        dd = dx * dx + dy * dy + dz * dz;
        dt = vx * dx + vy * dy + vz * dz;
        if (l2 * dd >= 4 * dt * dt) begin
            // The projection falls on the segment: distance to the line.
            cx = vy * dz - vz * dy;
            cy = vz * dx - vx * dz;
            cz = vx * dy - vy * dx;
            return (cx * cx + cy * cy + cz * cz) < r2 * dd;
        end
        // Beyond an end: distance to the nearer end point, kept in squares.
        a4 = 4 * vv + l2 - 4 * r2;
        if (a4 < 0) begin
            return 1'b1;
        end
        return (a4 * a4 * dd) < 16 * l2 * dt * dt;
    endfunction

    // The checker takes every strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hit=%0b",
                         $time, o_hit);
                error_count++;
            end else if (o_hit !== expected_hits[0]) begin
                $display("%0t: hit mismatch, expected %0b, actual %0b",
                         $time, expected_hits[0], o_hit);
                error_count++;
                void'(expected_hits.pop_front());
            end else begin
                void'(expected_hits.pop_front());
            end
        end
    end

    // The watchdog counts cycles in which nothing moves at all.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Sends one sphere; inputs change on the falling edge and the item counts
    // as accepted at the first rising edge where busy is low. The radius word
    // carries the 31-bit field in its low bits.
    task automatic send_sphere(logic signed [31:0] sx, logic signed [31:0] sy,
                               logic signed [31:0] sz, logic [31:0] sr);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 2) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_sphere_x <= sx;
        i_sphere_y <= sy;
        i_sphere_z <= sz;
        i_sphere_radius <= sr[30:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_hits.push_back(sphere_overlaps(sx, sy, sz, sr[30:0]));
    endtask

    // Registers change only once the pipeline has drained.
    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_hits.size() != 0) @(negedge i_clk);
        repeat (LAT + 2) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CENTER_X: cap_cx = value;
            REG_CENTER_Y: cap_cy = value;
            REG_CENTER_Z: cap_cz = value;
            REG_AXIS_X:   cap_dx = value;
            REG_AXIS_Y:   cap_dy = value;
            REG_AXIS_Z:   cap_dz = value;
            REG_LENGTH:   cap_len = value[30:0];
            default:      cap_rad = value[30:0];
        endcase
    endtask

    task automatic set_capsule(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                               logic [31:0] len, logic [31:0] rad);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_AXIS_X, dx);
        write_reg(REG_AXIS_Y, dy);
        write_reg(REG_AXIS_Z, dz);
        write_reg(REG_LENGTH, len);
        write_reg(REG_RADIUS, rad);
    endtask

    // Reset capsule: unit segment along x, no radius. Spheres touching the
    // side and the end exactly must miss, one step closer must hit.
    task automatic test_touching();
        send_sphere(0, 2 * ONE, 0, 2 * ONE);
        send_sphere(0, 2 * ONE, 0, 2 * ONE + 1);
        send_sphere(ONE + ONE / 2, 0, 0, ONE);
        send_sphere(ONE + ONE / 2, 0, 0, ONE + 1);
        send_sphere(-ONE - ONE / 2, 0, 0, ONE);
        send_sphere(-ONE / 2, 0, 0, 0);
        send_sphere(ONE / 2, 0, 0, 0);
    endtask

    // Field extremes against the reset capsule.
    task automatic test_extremes();
        send_sphere(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'h7FFF_FFFF);
        send_sphere(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h7FFF_FFFF);
        send_sphere(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
        send_sphere(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'h4000_0000);
    endtask

    // A zero direction and a zero length both reduce to a sphere test.
    task automatic test_degenerate();
        set_capsule(0, 0, 0, 0, 0, 0, ONE, 0);
        send_sphere(3 * ONE, 4 * ONE, 0, 5 * ONE);
        send_sphere(3 * ONE, 4 * ONE, 0, 5 * ONE + 1);
        set_capsule(0, 0, 0, ONE, ONE, 0, 0, ONE);
        send_sphere(0, 3 * ONE, 4 * ONE, 4 * ONE);
        send_sphere(0, 3 * ONE, 4 * ONE, 4 * ONE + 1);
    endtask

    // Every register at its extreme values at once, then the most negative x axis with length 1.
    task automatic test_register_extremes();
        set_capsule(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sphere(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'h7FFF_FFFF);
        send_sphere(0, 0, 0, 0);
        send_sphere(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        set_capsule(0, 0, 0, 32'h8000_0000, 0, 0, 1, 0);
        send_sphere(0, 0, 0, 0);
        send_sphere(0, 0, 0, 1);
    endtask

    function automatic logic signed [31:0] near_value(logic signed [31:0] base);
        int unsigned mag;
        mag = 32'd1 << $urandom_range(4, 26);
        return base + $signed($urandom_range(0, mag)) - $signed(mag / 2);
    endfunction

    // Random capsules, alternately fully random and of moderate size, with spheres
    // placed near the capsule so both outcomes show up, plus some anywhere in the field range.
    task automatic test_random(int count);
        logic signed [31:0] sx, sy, sz;
        logic [31:0] sr;
        int unsigned scale;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                if (n % 300 == 0) begin
                    set_capsule($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom);
                end else begin
                    scale = $urandom_range(8, 24);
                    set_capsule($urandom_range(0, 1 << scale), -$urandom_range(0, 1 << scale),
                                $urandom_range(0, 1 << scale),
                                $signed($urandom_range(0, 1 << scale)) - (1 << (scale - 1)),
                                $signed($urandom_range(0, 1 << scale)) - (1 << (scale - 1)),
                                ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1 << scale),
                                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 1 << scale),
                                $urandom_range(0, 1 << (scale - 2)));
                end
            end
            no_idle = (n >= 400 && n < 700);
            if ($urandom_range(0, 9) < 2) begin
                sx = $urandom;
                sy = $urandom;
                sz = $urandom;
                sr = $urandom & 32'h7FFF_FFFF;
            end else begin
                sx = near_value(cap_cx);
                sy = near_value(cap_cy);
                sz = near_value(cap_cz);
                sr = $urandom_range(0, 1 << $urandom_range(2, 24));
            end
            send_sphere(sx, sy, sz, sr);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        error_count = 0;
        stall_cycles = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_sphere_x = '0;
        i_sphere_y = '0;
        i_sphere_z = '0;
        i_sphere_radius = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_CENTER_X;
        i_cfg_data = '0;
        cap_cx = 0;
        cap_cy = 0;
        cap_cz = 0;
        cap_dx = ONE;
        cap_dy = 0;
        cap_dz = 0;
        cap_len = 31'd65536;
        cap_rad = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_touching();
        test_extremes();
        test_degenerate();
        test_register_extremes();
        test_random(1100);

        // Drain the pipeline, then allow its latency once more for strays.
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_hits.size() != 0) @(negedge i_clk);
        repeat (LAT + 5) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
